[sv/bfmd_pkg.sv]
package bfmd_pkg;

	// Field widths of the pixel stream and the configuration port.
	localparam int PIX_W      = 32;
	localparam int CH_W       = 8;
	localparam int SUM_W      = 9;
	localparam int NUM_CH     = 4;
	localparam int PAIR_W     = NUM_CH * SUM_W;
	localparam int REG_W      = 13;
	localparam int CFG_IDX_W  = 8;
	localparam int ROW_W      = 12;

	// Height clamp and register reset values.
	localparam logic [REG_W-1:0] HEIGHT_LIMIT = 13'd4096;
	localparam logic [REG_W-1:0] DIM_RESET    = 13'd2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 8'd1;

	typedef logic [PIX_W-1:0]  pixel_t;
	typedef logic [PAIR_W-1:0] pair_t;

	// One averaging job handed from the control stage to the averaging stage.
	typedef struct packed {
		logic  valid;
		logic  self_avg;
		logic  last;
		pair_t pair;
	} avg_job_t;

	// Per-channel sum of two pixels, packed as four 9-bit fields.
	function automatic pair_t pair_add(input pixel_t a, input pixel_t b);
		pair_t r;
		r = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			r[c*SUM_W +: SUM_W] = SUM_W'(a[c*CH_W +: CH_W]) + SUM_W'(b[c*CH_W +: CH_W]);
		end
		return r;
	endfunction

	// Adds two packed pair sums per channel and divides each by four.
	function automatic pixel_t quad_average(input pair_t top, input pair_t bottom);
		pixel_t           r;
		logic [SUM_W:0]   s;
		r = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			s = (SUM_W+1)'(top[c*SUM_W +: SUM_W]) + (SUM_W+1)'(bottom[c*SUM_W +: SUM_W]);
			r[c*CH_W +: CH_W] = s[CH_W+1:2];
		end
		return r;
	endfunction

endpackage

[sv/bfmd_if.sv]
interface bfmd_src_if;
	import bfmd_pkg::*;
	logic   valid;
	logic   ready;
	pixel_t texel;
	modport source (output valid, output texel, input ready);
	modport sink (input valid, input texel, output ready);
endinterface

interface bfmd_dst_if;
	import bfmd_pkg::*;
	logic   valid;
	logic   ready;
	pixel_t mip_texel;
	logic   last_of_level;
	modport source (output valid, output mip_texel, output last_of_level, input ready);
	modport sink (input valid, input mip_texel, input last_of_level, output ready);
endinterface

interface bfmd_cfg_if;
	import bfmd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [REG_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[sv/bfmd_line_ram.sv]
module bfmd_line_ram #(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic                  rd_en,
	input  logic [ADDR_W-1:0]     addr,
	input  bfmd_pkg::pair_t       wr_data,
	output bfmd_pkg::pair_t       rd_data
);
	import bfmd_pkg::*;

	pair_t mem [DEPTH];
	pair_t rd_data_q;

	// Single-port line memory; read data is registered and holds between reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/bfmd_ctrl.sv]
module bfmd_ctrl #(
	parameter int MAX_WIDTH = 4096,
	parameter int ADDR_W    = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  bfmd_pkg::pixel_t           texel,
	input  logic                       cfg_write,
	input  logic [bfmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfmd_pkg::REG_W-1:0] cfg_data,
	output logic                       ram_wr_en,
	output logic                       ram_rd_en,
	output logic [ADDR_W-1:0]          ram_addr,
	output bfmd_pkg::pair_t            ram_wr_data,
	output bfmd_pkg::avg_job_t         job
);
	import bfmd_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CMP_W = (COL_W + 1 > REG_W) ? COL_W + 1 : REG_W;

	logic [REG_W-1:0] src_width_q;
	logic [REG_W-1:0] src_height_q;
	pixel_t           hold_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [REG_W-1:0] eff_w;
	logic [REG_W-1:0] eff_h;
	logic [REG_W-1:0] dst_w;
	logic [REG_W-1:0] dst_h;
	logic             w_one;
	logic             h_one;
	logic [CMP_W-1:0] col_inc;
	logic [REG_W-1:0] row_inc;
	logic             col_last;
	logic             row_last;
	logic             have_pair;
	logic             emit;
	logic             last;
	pair_t            pair;

	// Effective dimensions after clamping the registers.
	always_comb begin
		priority if (src_width_q == '0) begin
			eff_w = REG_W'(1);
		end else if (32'(src_width_q) > MAX_WIDTH) begin
			eff_w = REG_W'(MAX_WIDTH);
		end else begin
			eff_w = src_width_q;
		end
		priority if (src_height_q == '0) begin
			eff_h = REG_W'(1);
		end else if (src_height_q > HEIGHT_LIMIT) begin
			eff_h = HEIGHT_LIMIT;
		end else begin
			eff_h = src_height_q;
		end
		w_one = (eff_w == REG_W'(1));
		h_one = (eff_h == REG_W'(1));
		dst_w = w_one ? REG_W'(1) : (eff_w >> 1);
		dst_h = h_one ? REG_W'(1) : (eff_h >> 1);
	end

	// Position decode, pair sum and line buffer requests for the incoming pixel.
	always_comb begin
		col_inc   = CMP_W'(col_q) + CMP_W'(1);
		row_inc   = REG_W'(row_q) + REG_W'(1);
		col_last  = (col_inc >= CMP_W'(eff_w));
		row_last  = (row_inc >= eff_h);
		have_pair = w_one || col_q[0];
		pair      = pair_add(w_one ? texel : hold_q, texel);
		ram_addr  = ADDR_W'(col_q >> 1);
		emit      = have_pair && (h_one || row_q[0]);
		last      = ((CMP_W'(ram_addr) + CMP_W'(1)) == CMP_W'(dst_w)) &&
		            ((REG_W'(row_q >> 1) + REG_W'(1)) == dst_h);

		ram_wr_en   = accept && have_pair && !h_one && !row_q[0] && !row_last;
		ram_rd_en   = accept && have_pair && !h_one && row_q[0];
		ram_wr_data = pair;

		job.valid    = accept && emit;
		job.self_avg = h_one;
		job.last     = last;
		job.pair     = pair;
	end

	// Configuration registers; any write restarts the level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= DIM_RESET;
			src_height_q <= DIM_RESET;
		end else if (cfg_write) begin
			if (cfg_index == CFG_SRC_WIDTH) begin
				src_width_q <= cfg_data;
			end
			if (cfg_index == CFG_SRC_HEIGHT) begin
				src_height_q <= cfg_data;
			end
		end
	end

	// Raster position and the held even-column pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			hold_q <= '0;
		end else if (cfg_write) begin
			col_q  <= '0;
			row_q  <= '0;
			hold_q <= '0;
		end else if (accept) begin
			if (!col_q[0] && !col_last) begin
				hold_q <= texel;
			end
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : ROW_W'(row_inc);
			end else begin
				col_q <= COL_W'(col_inc);
			end
		end
	end

endmodule

[sv/bfmd_avg.sv]
module bfmd_avg (
	input  logic                clk,
	input  logic                arst_n,
	input  bfmd_pkg::avg_job_t  job,
	input  bfmd_pkg::pair_t     line_pair,
	output logic                take_ok,
	output logic                dst_valid,
	input  logic                dst_ready,
	output bfmd_pkg::pixel_t    mip_texel,
	output logic                last_of_level
);
	import bfmd_pkg::*;

	avg_job_t job_s1;
	logic     out_valid_q;
	pixel_t   out_pixel_q;
	logic     out_last_q;
	logic     out_free;
	logic     move_s1;

	// The output register frees when empty or when its beat is taken.
	assign out_free = !out_valid_q || dst_ready;
	assign move_s1  = job_s1.valid && out_free;
	assign take_ok  = !job_s1.valid || out_free;

	// Stage 1 waits for the line buffer read that was issued with the pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_s1 <= '0;
		end else if (take_ok) begin
			job_s1 <= job;
		end
	end

	// Final per-channel add and divide into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (dst_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_pixel_q <= quad_average(job_s1.self_avg ? job_s1.pair : line_pair, job_s1.pair);
			out_last_q  <= job_s1.last;
		end
	end

	assign dst_valid     = out_valid_q;
	assign mip_texel     = out_pixel_q;
	assign last_of_level = out_last_q;

endmodule

[sv/box_filter_mip_downsample_unit.sv]
// 2x2 box-filter mipmap downsampler for ARGB8888. Source pixels of one level enter in
// raster order, one per clock; every second pixel of every odd row yields one averaged
// destination pixel via the stage 1 register and the output register, marked
// last_of_level on the final one. A single column pairs each pixel with itself, and a
// single row pairs each pair sum with itself, so then its only row gives results.
// The rate is set by the single-port line buffer, which takes at most one access per
// source pixel pair: even rows write horizontal pair sums, odd rows read them back, so one row
// never both reads and writes the same entry. The source side stalls only while a
// result waits in the output register with a second one queued behind it.
// The line buffer is not cleared after reset; a level only reads entries that its own
// even rows wrote. A write to the configuration port restarts the level and must be
// done while the block is idle.
module box_filter_mip_downsample_unit #(
	parameter int MAX_WIDTH = 4096
) (
	input logic        clk,
	input logic        arst_n,
	bfmd_src_if.sink   src,
	bfmd_dst_if.source dst,
	bfmd_cfg_if.sink   cfg
);
	import bfmd_pkg::*;

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic              accept;
	logic              take_ok;
	logic              ram_wr_en;
	logic              ram_rd_en;
	logic [ADDR_W-1:0] ram_addr;
	pair_t             ram_wr_data;
	pair_t             ram_rd_data;
	avg_job_t          job;

	// Handshakes.
	assign cfg.ready = 1'b1;
	assign src.ready = take_ok;
	assign accept    = src.valid && take_ok;

	bfmd_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.ADDR_W    (ADDR_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.texel       (src.texel),
		.cfg_write   (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.ram_wr_en   (ram_wr_en),
		.ram_rd_en   (ram_rd_en),
		.ram_addr    (ram_addr),
		.ram_wr_data (ram_wr_data),
		.job         (job)
	);

	bfmd_line_ram #(
		.DEPTH  (LINE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.rd_en   (ram_rd_en),
		.addr    (ram_addr),
		.wr_data (ram_wr_data),
		.rd_data (ram_rd_data)
	);

	bfmd_avg u_avg (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (job),
		.line_pair     (ram_rd_data),
		.take_ok       (take_ok),
		.dst_valid     (dst.valid),
		.dst_ready     (dst.ready),
		.mip_texel     (dst.mip_texel),
		.last_of_level (dst.last_of_level)
	);

endmodule

[sv/bfmd_checker.sv]
module bfmd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        src_valid,
	input logic        src_ready,
	input logic        dst_valid,
	input logic        dst_ready,
	input logic [31:0] mip_texel,
	input logic        last_of_level
);

	logic src_seen_q;

	// Remembers that at least one source beat has been taken since reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_seen_q <= 1'b0;
		end else if (src_valid && src_ready) begin
			src_seen_q <= 1'b1;
		end
	end

	// A stalled result beat stays offered.
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid)
		else $error("result beat withdrawn while stalled");

	// A stalled result beat keeps its payload.
	a_dst_stable: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> $stable(mip_texel) && $stable(last_of_level))
		else $error("result payload changed while stalled");

	// The source side only stalls behind a stalled, full output.
	a_src_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!src_ready |-> dst_valid && !dst_ready)
		else $error("source stalled without output back-pressure");

	// No result beat appears before any source beat has been taken.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> src_seen_q)
		else $error("result beat without any source beat");

endmodule

bind box_filter_mip_downsample_unit bfmd_checker u_bfmd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.src_valid     (src.valid),
	.src_ready     (src.ready),
	.dst_valid     (dst.valid),
	.dst_ready     (dst.ready),
	.mip_texel     (dst.mip_texel),
	.last_of_level (dst.last_of_level)
);

[sim/box_filter_mip_downsample_unit_tb.sv]
`timescale 1ns / 100ps

module box_filter_mip_downsample_unit_tb;
	import bfmd_pkg::*;

	localparam int                   LINE_MAX_WIDTH = 4096;
	localparam int                   LINE_ENTRIES   = LINE_MAX_WIDTH / 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX  = 8'hFF;
	localparam int                   HOLD_CYCLES    = 300;
	localparam int                   SETTLE_CYCLES  = 8;
	localparam int                   STALL_LIMIT    = 5000;
	localparam int                   RANDOM_ITEMS   = 580;

	// One expected destination beat.
	typedef struct {
		pixel_t pix;
		logic   last;
	} dst_beat_t;

	// Tracks the downsampler state and checks every destination beat in order.
	class mip_scoreboard;
		logic [REG_W-1:0] width_reg;
		logic [REG_W-1:0] height_reg;
		pair_t            row_pair_sums[LINE_ENTRIES];
		pixel_t           held_pixel;
		int unsigned      col;
		int unsigned      row;
		dst_beat_t        expected_beats[$];
		int               failures;

		function new();
			width_reg  = DIM_RESET;
			height_reg = DIM_RESET;
			held_pixel = '0;
			col        = 0;
			row        = 0;
			failures   = 0;
			foreach (row_pair_sums[i]) row_pair_sums[i] = '0;
		endfunction

		function int unsigned pending();
			return expected_beats.size();
		endfunction

		// Sizes after the out-of-range clamps.
		function int unsigned active_width();
			if (width_reg == 0) return 1;
			if (width_reg > LINE_MAX_WIDTH) return LINE_MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned active_height();
			if (height_reg == 0) return 1;
			if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
			return height_reg;
		endfunction

		function pair_t sum_channel_pairs(pixel_t a, pixel_t b);
			pair_t s;
			s = '0;
			for (int c = 0; c < NUM_CH; c++) begin
				s[c*SUM_W +: SUM_W] = {1'b0, a[c*CH_W +: CH_W]} + {1'b0, b[c*CH_W +: CH_W]};
			end
			return s;
		endfunction

		function pixel_t average_four(pair_t top, pair_t bottom);
			pixel_t      r;
			logic [9:0]  s;
			r = '0;
			for (int c = 0; c < NUM_CH; c++) begin
				s = {1'b0, top[c*SUM_W +: SUM_W]} + {1'b0, bottom[c*SUM_W +: SUM_W]};
				r[c*CH_W +: CH_W] = s[9:2];
			end
			return r;
		endfunction

		// Any register write, even to an unused index, restarts the level.
		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
			if (idx == CFG_SRC_WIDTH) begin
				width_reg = data;
			end else if (idx == CFG_SRC_HEIGHT) begin
				height_reg = data;
			end
			col        = 0;
			row        = 0;
			held_pixel = '0;
		endfunction

		function void note_pixel(pixel_t p);
			int unsigned w;
			int unsigned h;
			int unsigned dst_w;
			int unsigned dst_h;
			int unsigned idx;
			int unsigned dst_row;
			logic        have_pair;
			logic        emit;
			pair_t       pr;
			dst_beat_t   beat;
			w         = active_width();
			h         = active_height();
			have_pair = 1'b0;
			emit      = 1'b0;
			idx       = 0;
			dst_row   = 0;
			pr        = '0;
			beat.pix  = '0;

			// Horizontal pairing; a single column pairs with itself.
			if (w == 1) begin
				pr        = sum_channel_pairs(p, p);
				have_pair = 1'b1;
			end else if (col % 2 == 0) begin
				if (col + 1 < w) held_pixel = p;
			end else begin
				pr        = sum_channel_pairs(held_pixel, p);
				idx       = col / 2;
				have_pair = 1'b1;
			end

			// Vertical pairing through the line of pair sums.
			if (have_pair) begin
				dst_w = (w == 1) ? 1 : w / 2;
				dst_h = (h == 1) ? 1 : h / 2;
				if (h == 1) begin
					beat.pix = average_four(pr, pr);
					emit     = 1'b1;
				end else if (row % 2 == 0) begin
					if (row + 1 < h) row_pair_sums[idx] = pr;
				end else begin
					beat.pix = average_four(row_pair_sums[idx], pr);
					dst_row  = row / 2;
					emit     = 1'b1;
				end
				if (emit) begin
					beat.last = (idx + 1 == dst_w) && (dst_row + 1 == dst_h);
					expected_beats.push_back(beat);
				end
			end

			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		function void check_beat(pixel_t pix, logic last);
			dst_beat_t exp_beat;
			if (expected_beats.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("Unexpected beat: mip_texel %h last_of_level %b", pix, last);
				end
			end else begin
				exp_beat = expected_beats.pop_front();
				if (exp_beat.pix !== pix || exp_beat.last !== last) begin
					failures++;
					if (failures <= 10) begin
						$display("Mismatch: mip_texel expected %h got %h, last_of_level expected %b got %b",
							exp_beat.pix, pix, exp_beat.last, last);
					end
				end
			end
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bfmd_src_if src_ch ();
	bfmd_dst_if dst_ch ();
	bfmd_cfg_if cfg_ch ();

	box_filter_mip_downsample_unit #(
		.MAX_WIDTH(LINE_MAX_WIDTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_ch),
		.dst    (dst_ch),
		.cfg    (cfg_ch)
	);

	mip_scoreboard sb = new();

	int unsigned tx_idle_pct   = 0;
	int unsigned rx_idle_pct   = 0;
	int unsigned hold_requests = 0;
	int unsigned random_items  = 0;
	int unsigned idle_cycles   = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random back-pressure, plus a long hold-off on request.
	initial begin
		int unsigned hold_left;
		int unsigned hold_served;
		hold_left   = 0;
		hold_served = 0;
		dst_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
				dst_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				dst_ch.ready <= 1'b0;
			end else begin
				dst_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Every destination beat is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && dst_ch.valid && dst_ch.ready) begin
			sb.check_beat(dst_ch.mip_texel, dst_ch.last_of_level);
		end
	end

	// Watchdog on cycles in which no channel moves a beat.
	always @(posedge clk) begin
		if ((src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic pixel_t random_pixel();
		pixel_t p;
		for (int c = 0; c < NUM_CH; c++) begin
			case ($urandom_range(7))
				0: p[c*CH_W +: CH_W] = 8'h00;
				1: p[c*CH_W +: CH_W] = 8'hFF;
				default: p[c*CH_W +: CH_W] = CH_W'($urandom);
			endcase
		end
		return p;
	endfunction

	function automatic int unsigned clamped_dim(logic [REG_W-1:0] v);
		if (v == 0) return 1;
		if (v > LINE_MAX_WIDTH) return LINE_MAX_WIDTH;
		return v;
	endfunction

	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < tx_idle_pct) begin
			src_ch.valid <= 1'b0;
			@(posedge clk);
		end
		src_ch.valid <= 1'b1;
		src_ch.texel <= p;
		do @(posedge clk); while (!src_ch.ready);
		sb.note_pixel(p);
	endtask

	// Stop offering pixels until every expected beat has come out.
	task automatic wait_drained();
		src_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Registers change only with the block idle; beats without a result may
	// still be in the pipeline, so let a few more cycles pass.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.note_config(idx, data);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_size(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
		write_reg(CFG_SRC_WIDTH, w);
		write_reg(CFG_SRC_HEIGHT, h);
	endtask

	task automatic send_random_pixels(input int unsigned count);
		repeat (count) send_pixel(random_pixel());
	endtask

	initial begin
		logic [REG_W-1:0] w;
		logic [REG_W-1:0] h;
		int unsigned      level_pixels;
		int unsigned      count;

		src_ch.valid <= 1'b0;
		src_ch.texel <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_SRC_WIDTH;
		cfg_ch.data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: the reset size of 2x2 with extreme channel values.
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF);
		repeat (4) send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0303_0303);
		repeat (3) send_pixel(32'h0000_0000);

		// Odd width and odd height drop the trailing column and row.
		set_size(13'd3, 13'd3);
		send_random_pixels(9);

		// A single column, then a single row, then zero sizes acting as one.
		set_size(13'd1, 13'd2);
		send_random_pixels(2);
		set_size(13'd2, 13'd1);
		send_random_pixels(2);
		set_size(13'd0, 13'd0);
		send_pixel(random_pixel());

		// The receiver holds off while the sender keeps offering a whole level,
		// so the results back up and the source side stalls.
		set_size(13'd8, 13'd2);
		hold_requests++;
		send_random_pixels(16);

		// Random levels, mostly whole, some cut short by a restart.
		while (random_items < RANDOM_ITEMS) begin
			if (random_items < RANDOM_ITEMS / 3) begin
				tx_idle_pct = 15;
				rx_idle_pct = 81;
			end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 81;
				rx_idle_pct = 15;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case ($urandom_range(9))
				0: w = 13'd1;
				1: w = 13'd0;
				2: w = REG_W'($urandom_range(11, 64));
				default: w = REG_W'($urandom_range(2, 10));
			endcase
			case ($urandom_range(7))
				0: h = 13'd1;
				1: h = 13'd0;
				default: h = REG_W'($urandom_range(2, 8));
			endcase
			if ($urandom_range(5) == 0) begin
				write_reg(CFG_IDX_W'($urandom_range(CFG_SRC_HEIGHT + 1, CFG_SPARE_IDX)),
					REG_W'($urandom));
			end
			set_size(w, h);
			level_pixels = clamped_dim(w) * clamped_dim(h);
			if ($urandom_range(4) == 0) begin
				count = $urandom_range(1, level_pixels);
			end else begin
				count = level_pixels * $urandom_range(1, 2);
			end
			repeat (count) begin
				if (random_items >= RANDOM_ITEMS) break;
				send_pixel(random_pixel());
				random_items++;
				if (random_items == 120) hold_requests++;
				if (random_items == 400) wait_drained();
			end
		end

		// A restart through the unused index with all index bits set.
		write_reg(CFG_SPARE_IDX, 13'h1FFF);
		set_size(13'd4, 13'd2);
		send_random_pixels(8);

		// Largest sizes: the start of a clamped full-width row, of a clamped
		// full-height column, and of the largest level.
		set_size(13'h1FFF, 13'd0);
		send_random_pixels(40);
		set_size(13'd1, 13'h1FFF);
		send_random_pixels(40);
		set_size(13'd4096, 13'd4096);
		send_random_pixels(40);

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0) sb.failures++;
		if (sb.failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
